// ----- src/crtc_pkg.sv -----
// Package for the character-timing CRT controller.
// Holds bus opcodes, register indexes, write masks and the shared struct types.
// No dependencies.
package crtc_pkg;

    // Bus operation carried by each input transaction
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_RESET = 2'd3
    } t_opcode;

    // Bus port select
    localparam logic PORT_ADDR = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Register file geometry
    localparam int REG_COUNT  = 18;
    localparam int REG_STORED = 16;
    localparam int REG_SEL_W  = 5;
    localparam int REG_IDX_W  = 4;

    // Register indexes
    localparam logic [REG_SEL_W-1:0] REG_CLEAR_LIMIT = 5'd10;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_H    = 5'd14;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_L    = 5'd15;
    localparam logic [REG_SEL_W-1:0] REG_LPEN_H      = 5'd16;
    localparam logic [REG_SEL_W-1:0] REG_LPEN_L      = 5'd17;

    // Value returned by a read of a write-only register
    localparam logic [7:0] READ_UNUSED = 8'hff;

    // Width of the linear fetch address before it is cut to the address bus
    localparam int LIN_W = 24;

    // Interlace mode field value for interlaced-video mode
    localparam logic [1:0] MODE_INTERLACE_VIDEO = 2'd3;

    // Cursor blink modes
    localparam logic [1:0] CUR_STEADY     = 2'd0;
    localparam logic [1:0] CUR_BLINK_FAST = 2'd2;
    localparam logic [1:0] CUR_BLINK_SLOW = 2'd3;

    // Stored registers R0..R15
    typedef logic [REG_STORED-1:0][7:0] t_reg_bank;

    // Timing counters
    typedef struct packed {
        logic [7:0]  col;
        logic [13:0] scan;
        logic [13:0] row;
        logic [4:0]  raster;
        logic [4:0]  field;
    } t_counters;

    // Per-character timing flags
    typedef struct packed {
        logic [4:0] raster_addr;
        logic       display_enable;
        logic       hsync;
        logic       vsync;
        logic       cursor;
    } t_tick_flags;

    // Writable bits of each stored register
    function automatic logic [7:0] write_mask(input logic [REG_IDX_W-1:0] idx);
        logic [7:0] m;
        case (idx)
            4'd4, 4'd6, 4'd7, 4'd10, 4'd14: m = 8'h7f;
            4'd5, 4'd9, 4'd11:              m = 8'h1f;
            4'd8:                           m = 8'hf3;
            4'd12:                          m = 8'h3f;
            default:                        m = 8'hff;
        endcase
        if (idx == 4'd14) begin
            m = 8'h3f;
        end
        return m;
    endfunction

    // Character skew: code 3 means no skew
    function automatic logic [1:0] skew_of(input logic [1:0] v);
        return (v == 2'd3) ? 2'd0 : v;
    endfunction

endpackage

// ----- src/crtc_in_if.sv -----
// Input channel of the CRT controller: valid/ready handshake with bus payload.
// No dependencies.
interface crtc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       port;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output port, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input port, input write_data,
                    output ready);
endinterface

// ----- src/crtc_out_if.sv -----
// Result channel of the CRT controller: valid/ready handshake with timing payload.
// Address width follows the controller's ADDR_BITS parameter.
interface crtc_out_if #(
    parameter int ADDR_BITS = 14
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [4:0]           raster_addr;
    logic                 display_enable;
    logic                 hsync;
    logic                 vsync;
    logic                 cursor_out;
    logic [7:0]           read_data;

    modport source (output valid, output mem_addr, output raster_addr,
                    output display_enable, output hsync, output vsync,
                    output cursor_out, output read_data, input ready);
    modport sink   (input valid, input mem_addr, input raster_addr,
                    input display_enable, input hsync, input vsync,
                    input cursor_out, input read_data, output ready);
endinterface

// ----- src/crtc_regfile.sv -----
// Register file of the CRT controller: address select, masked writes, readback.
// Depends on crtc_pkg.
module crtc_regfile
    import crtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  logic       i_port,
    input  logic [7:0] i_data,
    output t_reg_bank  o_regs,
    output logic [7:0] o_read_data,
    output logic       o_clear
);

    t_reg_bank            r_regs;
    logic [REG_SEL_W-1:0] r_sel;

    // Update selection and registers on a bus write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
            r_sel  <= '0;
        end else if (i_wr_en) begin
            if (i_port == PORT_ADDR) begin
                if (i_data[REG_SEL_W-1:0] < REG_SEL_W'(REG_COUNT)) begin
                    r_sel <= i_data[REG_SEL_W-1:0];
                end
            end else if (r_sel < REG_SEL_W'(REG_STORED)) begin
                r_regs[r_sel[REG_IDX_W-1:0]] <=
                    i_data & write_mask(r_sel[REG_IDX_W-1:0]);
            end
        end
    end

    // Restart counters on a data write to a timing register
    assign o_clear = i_wr_en && (i_port == PORT_DATA) && (r_sel < REG_CLEAR_LIMIT);

    // Read back cursor registers; light pen reads zero; the rest are write-only
    always_comb begin
        case (r_sel) inside
            REG_CURSOR_H, REG_CURSOR_L: o_read_data = r_regs[r_sel[REG_IDX_W-1:0]];
            REG_LPEN_H, REG_LPEN_L:     o_read_data = '0;
            default:                    o_read_data = READ_UNUSED;
        endcase
    end

    assign o_regs = r_regs;

endmodule

// ----- src/crtc_tick.sv -----
// Per-character timing logic: position outputs and next counter values.
// Depends on crtc_pkg.
module crtc_tick
    import crtc_pkg::*;
#(
    parameter int ADDR_BITS = 14
) (
    input  t_reg_bank             i_regs,
    input  t_counters             i_ctr,
    output logic [ADDR_BITS-1:0]  o_mem_addr,
    output t_tick_flags           o_flags,
    output t_counters             o_next
);

    logic [1:0]       mode;
    logic [7:0]       r1;
    logic [8:0]       hpos;
    logic [9:0]       hend;
    logic [4:0]       vw;
    logic [13:0]      vend;
    logic [1:0]       skew_c;
    logic [1:0]       skew_k;
    logic [13:0]      start;
    logic [13:0]      cpos;
    logic [1:0]       cmode;
    logic             de;
    logic             blink_ok;
    logic [21:0]      prod;
    logic [LIN_W-1:0] lin;
    logic [LIN_W-1:0] lin_skewed;
    logic [8:0]       cols;
    logic [8:0]       col_inc;
    logic [5:0]       cl;
    logic [7:0]       rows_p1;
    logic [13:0]      total_base;
    logic [14:0]      total_raw;
    logic [14:0]      total;
    logic [14:0]      scan_inc;
    logic [13:0]      scan_wrap;
    logic             even;
    logic [4:0]       field_inc;
    logic [5:0]       rast_inc1;
    logic [6:0]       rast_inc2;
    logic [4:0]       rast_prog;
    logic [4:0]       rast_intl;

    // Decode register fields
    assign mode   = i_regs[8][1:0];
    assign r1     = i_regs[1];
    assign hpos   = {1'b0, i_regs[2]} + 9'd1;
    assign hend   = {1'b0, hpos} + {6'd0, i_regs[3][3:0]};
    assign vw     = (i_regs[3][7:4] == 4'd0) ? 5'd16 : {1'b0, i_regs[3][7:4]};
    assign vend   = 14'(i_regs[7]) + 14'(vw);
    assign skew_c = skew_of(i_regs[8][5:4]);
    assign skew_k = skew_of(i_regs[8][7:6]);
    assign start  = {i_regs[12][5:0], i_regs[13]};
    assign cpos   = {i_regs[14][5:0], i_regs[15]};
    assign cmode  = i_regs[10][6:5];

    // Sync windows and display enable
    assign o_flags.vsync = (i_ctr.row >= 14'(i_regs[7])) && (i_ctr.row < vend);
    assign o_flags.hsync = (10'(i_ctr.col) >= 10'(hpos)) && (10'(i_ctr.col) < hend);
    assign de = (i_ctr.col >= 8'(skew_c))
             && (9'(i_ctr.col) < (9'(r1) + 9'(skew_c)))
             && (i_ctr.row < 14'(i_regs[6]));
    assign o_flags.display_enable = de;
    assign o_flags.raster_addr    = i_ctr.raster;

    // Linear fetch address
    assign prod       = i_ctr.row * r1;
    assign lin        = LIN_W'(start) + LIN_W'(prod) + LIN_W'(i_ctr.col);
    assign lin_skewed = lin - LIN_W'(skew_c);
    assign o_mem_addr = de ? lin_skewed[ADDR_BITS-1:0] : '0;

    // Cursor match with blink
    assign blink_ok = (cmode == CUR_STEADY)
                   || ((cmode == CUR_BLINK_FAST) && !i_ctr.field[3])
                   || ((cmode == CUR_BLINK_SLOW) && !i_ctr.field[4]);
    assign o_flags.cursor = blink_ok
                         && (i_ctr.raster >= i_regs[10][4:0])
                         && (i_ctr.raster <= i_regs[11][4:0])
                         && de
                         && ((lin + LIN_W'(skew_c)) == (LIN_W'(cpos) + LIN_W'(skew_k)));

    // Frame geometry
    assign cols       = ({1'b0, i_regs[0]} < 9'd1) ? 9'd2 : ({1'b0, i_regs[0]} + 9'd1);
    assign cl         = (mode == MODE_INTERLACE_VIDEO) ? (6'(i_regs[9][4:0]) + 6'd2)
                                                       : (6'(i_regs[9][4:0]) + 6'd1);
    assign rows_p1    = {1'b0, i_regs[4][6:0]} + 8'd1;
    assign total_base = rows_p1 * cl;
    assign total_raw  = (mode == MODE_INTERLACE_VIDEO)
                      ? (15'(total_base) + 15'({i_regs[5][4:0], 1'b0}))
                      : ((15'(total_base) + 15'(i_regs[5][4:0])) << 1);
    assign total      = (total_raw < 15'd2) ? 15'd2 : total_raw;

    // Counter increments; each counter stays below its bound
    assign col_inc   = 9'(i_ctr.col) + 9'd1;
    assign scan_inc  = 15'(i_ctr.scan) + 15'd2;
    assign scan_wrap = (scan_inc >= total) ? 14'(scan_inc - total) : scan_inc[13:0];
    assign even      = !i_ctr.field[0];
    assign field_inc = i_ctr.field + 5'd1;
    assign rast_inc1 = 6'(i_ctr.raster) + 6'd1;
    assign rast_prog = (rast_inc1 == cl) ? 5'd0 : rast_inc1[4:0];
    assign rast_inc2 = 7'(i_ctr.raster) + 7'd2;
    assign rast_intl = (rast_inc2 >= 7'(cl)) ? 5'(rast_inc2 - 7'(cl)) : rast_inc2[4:0];

    // Advance column, then line, row and field at end of line
    always_comb begin
        o_next = i_ctr;
        if (col_inc == cols) begin
            o_next.col  = '0;
            o_next.scan = scan_wrap;
            if ((even && scan_wrap == 14'd0) || (!even && scan_wrap == 14'd1)) begin
                o_next.field  = field_inc;
                o_next.row    = '0;
                o_next.scan   = 14'(field_inc[0]);
                o_next.raster = (mode == MODE_INTERLACE_VIDEO) ? 5'(field_inc[0]) : 5'd0;
            end else if (mode != MODE_INTERLACE_VIDEO) begin
                o_next.raster = rast_prog;
                if (rast_prog == 5'd0) begin
                    o_next.row = i_ctr.row + 14'd1;
                end
            end else begin
                o_next.raster = rast_intl;
                if ((even && rast_intl == 5'd0) || (!even && rast_intl == 5'd1)) begin
                    o_next.row    = i_ctr.row + 14'd1;
                    o_next.raster = even ? 5'd0 : 5'd1;
                end
            end
        end else begin
            o_next.col = col_inc[7:0];
        end
    end

endmodule

// ----- src/crt_character_timing_controller_top.sv -----
// Character-timing CRT controller, top level.
// Result valid follows input acceptance through the input register, then the result register.
// Throughput: one transaction per cycle while the result channel is ready; the path
// through the row-times-width multiplier and the address compare sets the clock.
// Reset (synchronous, active low) clears registers, selection, counters and both stages.
// Depends on crtc_pkg, crtc_in_if, crtc_out_if, crtc_regfile and crtc_tick.
module crt_character_timing_controller_top
    import crtc_pkg::*;
#(
    parameter int ADDR_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crtc_in_if.sink           i_in,
    crtc_out_if.source        o_out
);

    logic                 r_in_valid;
    t_opcode              r_op;
    logic                 r_port;
    logic [7:0]           r_data;

    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_mem_addr;
    t_tick_flags          r_flags;
    logic [7:0]           r_read_data;

    t_counters            r_ctr;
    t_counters            n_ctr;

    logic                 advance;
    logic                 fire;
    logic                 is_tick;
    logic                 wr_en;
    logic                 wr_clear;
    t_reg_bank            regs;
    logic [7:0]           read_data;
    logic [ADDR_BITS-1:0] tick_addr;
    t_tick_flags          tick_flags;
    t_counters            tick_next;

    // Handshake: result stage frees when empty or taken
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;
    assign is_tick    = fire && (r_op == OP_TICK);
    assign wr_en      = fire && (r_op == OP_WRITE);

    // Capture input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= t_opcode'(i_in.opcode);
            r_port <= i_in.port;
            r_data <= i_in.write_data;
        end
    end

    crtc_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_port      (r_port),
        .i_data      (r_data),
        .o_regs      (regs),
        .o_read_data (read_data),
        .o_clear     (wr_clear)
    );

    crtc_tick #(
        .ADDR_BITS (ADDR_BITS)
    ) u_tick (
        .i_regs     (regs),
        .i_ctr      (r_ctr),
        .o_mem_addr (tick_addr),
        .o_flags    (tick_flags),
        .o_next     (tick_next)
    );

    // Select next counter state
    always_comb begin
        n_ctr = r_ctr;
        if (is_tick) begin
            n_ctr = tick_next;
        end else if (wr_clear || (fire && (r_op == OP_RESET))) begin
            n_ctr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else begin
            r_ctr <= n_ctr;
        end
    end

    // Load result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem_addr  <= is_tick ? tick_addr : '0;
            r_flags     <= is_tick ? tick_flags : '0;
            r_read_data <= (r_op == OP_READ) ? read_data : 8'd0;
        end
    end

    // Drive result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.mem_addr       = r_mem_addr;
    assign o_out.raster_addr    = r_flags.raster_addr;
    assign o_out.display_enable = r_flags.display_enable;
    assign o_out.hsync          = r_flags.hsync;
    assign o_out.vsync          = r_flags.vsync;
    assign o_out.cursor_out     = r_flags.cursor;
    assign o_out.read_data      = r_read_data;

endmodule

// ----- tb/sv/tb_crt_character_timing_controller_top.sv -----
// Self-checking testbench for the character-timing CRT controller top level.
// Drives bus and tick transactions, predicts every result and scores it in order.
// Depends on crtc_pkg, crtc_in_if, crtc_out_if and crt_character_timing_controller_top.
module tb_crt_character_timing_controller_top;
    import crtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS      = 14;
    localparam int RAND_ITEMS     = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Writable bits of R0..R15
    localparam logic [7:0] WR_MASK [REG_STORED] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
        8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff
    };

    typedef struct packed {
        logic [ADDR_BITS-1:0] mem_addr;
        logic [4:0]           raster_addr;
        logic                 display_enable;
        logic                 hsync;
        logic                 vsync;
        logic                 cursor_out;
        logic [7:0]           read_data;
    } t_result;

    // One directed transaction; fixed_exp rows carry their own vsync and read byte,
    // every other timing field of such a row is zero
    typedef struct packed {
        t_opcode    op;
        logic       port;
        logic [7:0] data;
        logic       fixed_exp;
        logic       vsync;
        logic [7:0] rdata;
    } t_dir_row;

    localparam int DIR_N = 25;
    localparam t_dir_row DIRECTED [DIR_N] = '{
        // first tick after reset: row 0 sits in the 16-row vertical sync window
        '{OP_TICK,  PORT_ADDR, 8'h00, 1'b1, 1'b1, 8'h00},
        // write-only register reads back as all ones
        '{OP_READ,  PORT_ADDR, 8'h00, 1'b1, 1'b0, 8'hff},
        // out-of-range select is dropped and the selection is kept
        '{OP_WRITE, PORT_ADDR, 8'hff, 1'b1, 1'b0, 8'h00},
        '{OP_READ,  PORT_DATA, 8'h00, 1'b1, 1'b0, 8'hff},
        // light pen register ignores writes
        '{OP_WRITE, PORT_ADDR, 8'h10, 1'b1, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hff, 1'b1, 1'b0, 8'h00},
        '{OP_READ,  PORT_DATA, 8'h00, 1'b1, 1'b0, 8'h00},
        // select R14 with junk in the upper bits, write all ones, read masked value
        '{OP_WRITE, PORT_ADDR, 8'hee, 1'b1, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hff, 1'b1, 1'b0, 8'h00},
        '{OP_READ,  PORT_ADDR, 8'h00, 1'b1, 1'b0, 8'h3f},
        // start address 0x3ffe, wide display, four columns
        '{OP_WRITE, PORT_ADDR, 8'h0c, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_ADDR, 8'h0d, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hfe, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_ADDR, 8'h01, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_ADDR, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'h03, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_ADDR, 8'h06, 1'b0, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
        // fetch address wraps past the top of the address space
        '{OP_TICK,  PORT_ADDR, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_TICK,  PORT_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_TICK,  PORT_ADDR, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_TICK,  PORT_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        // reset pulse keeps registers, result is all zero
        '{OP_RESET, PORT_DATA, 8'h5a, 1'b1, 1'b0, 8'h00}
    };

    logic i_clk;
    logic i_rst_n;

    crtc_in_if                            in_if ();
    crtc_out_if #(.ADDR_BITS(ADDR_BITS))  out_if ();

    crt_character_timing_controller_top #(
        .ADDR_BITS (ADDR_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted controller state
    logic [7:0]  crt_regs [REG_COUNT];
    int unsigned crt_sel;
    int unsigned crt_col;
    int unsigned crt_scan;
    int unsigned crt_row;
    int unsigned crt_ras;
    int unsigned crt_field;

    t_result expected_outputs [$];

    int src_gap_pct   = 17;
    int snk_stall_pct = 56;
    int item_count    = 0;
    int mismatch_count = 0;
    int idle_cycles   = 0;
    int n_ticks       = 0;
    int n_writes      = 0;
    int n_reads       = 0;
    int n_pulses      = 0;
    int n_cursor      = 0;
    int n_display     = 0;
    int n_programs    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clear timing counters and field count
    function automatic void clear_timing();
        crt_col   = 0;
        crt_scan  = 0;
        crt_row   = 0;
        crt_ras   = 0;
        crt_field = 0;
    endfunction

    // Compute the result of one bus transaction and advance the predicted state
    function automatic t_result predict_crtc_output(t_opcode op, logic port,
                                                    logic [7:0] data);
        t_result     r;
        int unsigned mode, r1, hpos, hw, vpos, vw, sk_c, sk_k;
        int unsigned start, cpos, cmode, cfirst, clast, lin;
        int unsigned cols, lines, total;
        logic        de, blink_ok, even;
        r = '0;
        case (op)
            OP_TICK: begin
                mode   = crt_regs[8][1:0];
                r1     = crt_regs[1];
                hpos   = crt_regs[2] + 1;
                hw     = crt_regs[3][3:0];
                vpos   = crt_regs[7];
                vw     = (crt_regs[3][7:4] == 4'd0) ? 16 : crt_regs[3][7:4];
                sk_c   = (crt_regs[8][5:4] == 2'd3) ? 0 : crt_regs[8][5:4];
                sk_k   = (crt_regs[8][7:6] == 2'd3) ? 0 : crt_regs[8][7:6];
                start  = {crt_regs[12][5:0], crt_regs[13]};
                cpos   = {crt_regs[14][5:0], crt_regs[15]};
                cmode  = crt_regs[10][6:5];
                cfirst = crt_regs[10][4:0];
                clast  = crt_regs[11][4:0];

                // report current position
                r.vsync = (crt_row >= vpos) && (crt_row < vpos + vw);
                r.hsync = (crt_col >= hpos) && (crt_col < hpos + hw);
                de = (crt_col >= sk_c) && (crt_col < r1 + sk_c) && (crt_row < crt_regs[6]);
                r.display_enable = de;
                blink_ok = (cmode == CUR_STEADY) ||
                           (cmode == CUR_BLINK_FAST && (crt_field % 16) < 8) ||
                           (cmode == CUR_BLINK_SLOW && (crt_field % 32) < 16);
                lin = start + crt_row * r1 + crt_col;
                r.cursor_out = blink_ok && crt_ras >= cfirst && crt_ras <= clast && de &&
                               (lin + sk_c == cpos + sk_k);
                r.mem_addr    = de ? ADDR_BITS'(lin - sk_c) : '0;
                r.raster_addr = crt_ras[4:0];

                // frame geometry
                cols = crt_regs[0] + 1;
                if (cols < 2) begin
                    cols = 2;
                end
                lines = (mode == MODE_INTERLACE_VIDEO) ? crt_regs[9][4:0] + 2
                                                       : crt_regs[9][4:0] + 1;
                total = (crt_regs[4][6:0] + 1) * lines;
                if (mode == MODE_INTERLACE_VIDEO) begin
                    total = total + 2 * crt_regs[5][4:0];
                end else begin
                    total = 2 * (total + crt_regs[5][4:0]);
                end
                if (total < 2) begin
                    total = 2;
                end

                // advance column, scan, raster and row at line end, field at frame end
                crt_col = (crt_col + 1) % cols;
                if (crt_col == 0) begin
                    crt_scan = (crt_scan + 2) % total;
                    even = (crt_field[0] == 1'b0);
                    if ((even && crt_scan == 0) || (!even && crt_scan == 1)) begin
                        crt_field = (crt_field + 1) & 32'h1f;
                        crt_row   = 0;
                        crt_col   = 0;
                        crt_scan  = crt_field & 1;
                        crt_ras   = (mode == MODE_INTERLACE_VIDEO) ? (crt_field & 1) : 0;
                    end else if (mode != MODE_INTERLACE_VIDEO) begin
                        crt_ras = ((crt_ras + 1) % lines) & 32'h1f;
                        if (crt_ras == 0) begin
                            crt_row = (crt_row + 1) & 32'h3fff;
                        end
                    end else begin
                        crt_ras = ((crt_ras + 2) % lines) & 32'h1f;
                        if ((even && crt_ras == 0) || (!even && crt_ras == 1)) begin
                            crt_row = (crt_row + 1) & 32'h3fff;
                            crt_ras = even ? 0 : 1;
                        end
                    end
                end
            end
            OP_WRITE: begin
                if (port == PORT_ADDR) begin
                    if (data[4:0] < REG_COUNT) begin
                        crt_sel = data[4:0];
                    end
                end else if (crt_sel < REG_STORED) begin
                    crt_regs[crt_sel] = data & WR_MASK[crt_sel];
                    if (crt_sel < REG_CLEAR_LIMIT) begin
                        clear_timing();
                    end
                end
            end
            OP_READ: begin
                r.read_data = (crt_sel >= REG_CURSOR_H && crt_sel < REG_COUNT)
                              ? crt_regs[crt_sel] : READ_UNUSED;
            end
            default: begin
                clear_timing();
            end
        endcase
        return r;
    endfunction

    // Offer one transaction, wait for acceptance, queue its expected result.
    // Entered and left at a falling edge.
    task automatic push_bus_txn(input t_opcode op, input logic port, input logic [7:0] data,
                                input logic use_fixed, input t_result fixed_res);
        t_result r;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.port       <= port;
        in_if.write_data <= data;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_crtc_output(op, port, data);
        expected_outputs.push_back(use_fixed ? fixed_res : r);
        item_count++;
        case (op)
            OP_TICK:  n_ticks++;
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            default:  n_pulses++;
        endcase
        n_cursor  += r.cursor_out;
        n_display += r.display_enable;
        @(negedge i_clk);
    endtask

    // Load a random but sane frame layout into R0..R15
    task automatic program_frame();
        logic [7:0]  v [REG_STORED];
        int unsigned start, cur;
        int          i;
        v[0]  = 8'($urandom_range(1, 12));
        v[1]  = 8'($urandom_range(0, v[0] + 1));
        v[2]  = 8'($urandom_range(0, v[0]));
        v[3]  = 8'($urandom_range(0, 255));
        v[4]  = 8'($urandom_range(0, 4));
        v[5]  = 8'($urandom_range(0, 3));
        v[6]  = 8'($urandom_range(0, 5));
        v[7]  = 8'($urandom_range(0, 6));
        v[8]  = 8'($urandom_range(0, 255));
        v[9]  = ($urandom_range(0, 9) == 0) ? 8'd31 : 8'($urandom_range(0, 3));
        v[10] = {1'b0, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 2))};
        v[11] = 8'($urandom_range(0, 31));
        v[12] = 8'($urandom_range(0, 255));
        v[13] = 8'($urandom_range(0, 255));
        // park the cursor a few characters past the start address
        start = {v[12][5:0], v[13]};
        cur   = (start + $urandom_range(0, 40)) & 32'h3fff;
        v[14] = {2'($urandom_range(0, 3)), cur[13:8]};
        v[15] = cur[7:0];
        // push some registers to their extremes
        for (i = 0; i < REG_STORED; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                v[i] = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            end
        end
        for (i = 0; i < REG_STORED; i++) begin
            push_bus_txn(OP_WRITE, PORT_ADDR, {3'($urandom_range(0, 7)), 5'(i)}, 1'b0, '0);
            push_bus_txn(OP_WRITE, PORT_DATA, v[i], 1'b0, '0);
        end
        n_programs++;
    endtask

    // Stimulus
    initial begin
        t_result fixed;
        int      k, n, phase, last_phase;
        in_if.valid      = 1'b0;
        in_if.opcode     = OP_TICK;
        in_if.port       = PORT_ADDR;
        in_if.write_data = 8'h00;
        i_rst_n          = 1'b0;
        for (k = 0; k < REG_COUNT; k++) begin
            crt_regs[k] = 8'h00;
        end
        crt_sel = 0;
        clear_timing();

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (k = 0; k < DIR_N; k++) begin
            fixed           = '0;
            fixed.vsync     = DIRECTED[k].vsync;
            fixed.read_data = DIRECTED[k].rdata;
            push_bus_txn(DIRECTED[k].op, DIRECTED[k].port, DIRECTED[k].data,
                         DIRECTED[k].fixed_exp, fixed);
        end

        // random part: mostly tick bursts, some programmed frames, plus bus noise
        last_phase = 0;
        while (item_count < DIR_N + RAND_ITEMS) begin
            phase = (item_count - DIR_N) * 3 / RAND_ITEMS;
            if (phase != last_phase) begin
                // hold off until every queued result has drained
                in_if.valid <= 1'b0;
                do @(negedge i_clk); while (expected_outputs.size() != 0);
                last_phase = phase;
            end
            case (phase)
                0:       begin src_gap_pct = 17; snk_stall_pct = 56; end
                1:       begin src_gap_pct = 56; snk_stall_pct = 17; end
                default: begin src_gap_pct = 0;  snk_stall_pct = 0;  end
            endcase
            n = $urandom_range(0, 99);
            if (n < 12) begin
                program_frame();
            end else if (n < 80) begin
                repeat ($urandom_range(4, 60)) begin
                    push_bus_txn(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 1'b0, '0);
                end
            end else if (n < 87) begin
                push_bus_txn(OP_WRITE, PORT_ADDR, 8'($urandom_range(0, 255)), 1'b0, '0);
                push_bus_txn(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'b0, '0);
            end else if (n < 92) begin
                push_bus_txn(OP_RESET, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'b0, '0);
            end else begin
                push_bus_txn(t_opcode'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
        in_if.valid <= 1'b0;

        // drain, then give late results a chance to show up
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions: %0d ticks, %0d writes, %0d reads, %0d reset pulses",
                 item_count, n_ticks, n_writes, n_reads, n_pulses);
        $display("  %0d frame programs, %0d displayed characters, %0d cursor hits",
                 n_programs, n_display, n_cursor);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side back-pressure
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Compare one field of a result
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Score each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_outputs.size() == 0) begin
                $error("result transaction with no expectation pending");
                mismatch_count++;
            end else begin
                want = expected_outputs.pop_front();
                check_field("mem_addr",       want.mem_addr,       out_if.mem_addr);
                check_field("raster_addr",    want.raster_addr,    out_if.raster_addr);
                check_field("display_enable", want.display_enable, out_if.display_enable);
                check_field("hsync",          want.hsync,          out_if.hsync);
                check_field("vsync",          want.vsync,          out_if.vsync);
                check_field("cursor_out",     want.cursor_out,     out_if.cursor_out);
                check_field("read_data",      want.read_data,      out_if.read_data);
            end
        end
    end

    // Count cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
